FILE: rtl/fsv_pkg.sv
// shared types, character codes and constants of the position string validator
package fsv_pkg;

    // default depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH_DEF = 2;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_LO_W  = 8'h77;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_K  = 8'h4B;
    localparam logic [7:0] CH_UP_Q  = 8'h51;
    localparam logic [7:0] CH_LO_K  = 8'h6B;
    localparam logic [7:0] CH_LO_Q  = 8'h71;

    // token numbers
    localparam logic [2:0] TOK_PLACE    = 3'd1;
    localparam logic [2:0] TOK_SIDE     = 3'd2;
    localparam logic [2:0] TOK_CASTLE   = 3'd3;
    localparam logic [2:0] TOK_EP       = 3'd4;
    localparam logic [2:0] TOK_HALFMOVE = 3'd5;
    localparam logic [2:0] TOK_FULLMOVE = 3'd6;
    localparam logic [2:0] TOK_MAX      = 3'd7;

    // board limits
    localparam logic [3:0] FILE_COUNT = 4'd8;
    localparam logic [2:0] RANK_TOP   = 3'd7;

    // largest signed 32-bit magnitude
    localparam logic [30:0] INT_LIMIT = 31'h7FFF_FFFF;

    // classified input beat
    typedef struct packed {
        logic       is_end;
        logic       is_space;
        logic       is_slash;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_piece;
        logic       is_castle;
        logic [1:0] castle_idx;
        logic       is_wb;
        logic       is_ah;
        logic       is_18;
    } fsv_item_t;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } fsv_qstat_t;

    // number token flags
    typedef struct packed {
        logic over;
        logic nonzero;
        logic digit;
        logic minus;
    } fsv_numflags_t;

endpackage

FILE: rtl/fsv_front.sv
// front part: input handshake and character classification
module fsv_front
    import fsv_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       is_end,
    input  fsv_qstat_t qstat,
    output logic       push,
    output fsv_item_t  item
);

    // accept while the queue has room
    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;

    // classify the byte
    always_comb
    begin
        item            = '0;
        item.is_end     = is_end;
        item.is_space   = (char_code == CH_SPACE) ||
                          (char_code >= CH_TAB && char_code <= CH_CR);
        item.is_slash   = (char_code == CH_SLASH);
        item.is_minus   = (char_code == CH_MINUS);
        item.is_digit   = (char_code >= CH_ZERO && char_code <= CH_NINE);
        item.digit      = char_code[3:0];
        item.is_wb      = (char_code == CH_LO_W) || (char_code == CH_LO_B);
        item.is_ah      = (char_code >= CH_LO_A && char_code <= CH_LO_H);
        item.is_18      = (char_code >= CH_ONE && char_code <= CH_EIGHT);
        unique case (char_code)
            8'h50, 8'h4E, 8'h42, 8'h52, 8'h51, 8'h4B,
            8'h70, 8'h6E, 8'h62, 8'h72, 8'h71, 8'h6B: item.is_piece = 1'b1;
            default:                                  item.is_piece = 1'b0;
        endcase
        unique case (char_code)
            CH_UP_K:
            begin
                item.is_castle  = 1'b1;
                item.castle_idx = 2'd0;
            end
            CH_UP_Q:
            begin
                item.is_castle  = 1'b1;
                item.castle_idx = 2'd1;
            end
            CH_LO_K:
            begin
                item.is_castle  = 1'b1;
                item.castle_idx = 2'd2;
            end
            CH_LO_Q:
            begin
                item.is_castle  = 1'b1;
                item.castle_idx = 2'd3;
            end
            default:
            begin
                item.is_castle  = 1'b0;
                item.castle_idx = 2'd0;
            end
        endcase
    end

endmodule

FILE: rtl/fsv_queue.sv
// short queue of classified beats between front and back
module fsv_queue
    import fsv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  fsv_item_t  push_item,
    input  logic       pop,
    output fsv_item_t  head_item,
    output fsv_qstat_t qstat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    fsv_item_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // status and head
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CNT_FULL);
    assign head_item   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/fsv_back.sv
// back part: token and field checks, verdict register
module fsv_back
    import fsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fsv_item_t  head_item,
    input  fsv_qstat_t qstat,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       fen_valid
);

    logic          tok_lt6;
    logic [2:0]    tok_reg, tok_next, tok_eff;
    logic          inside_reg, inside_next;
    logic          failed_reg, failed_next;
    logic [1:0]    cic_reg, cic_next;
    logic          first_minus_reg, first_minus_next;
    logic          first_wb_reg, first_wb_next;
    logic          first_ah_reg, first_ah_next;
    logic [2:0]    rank_reg, rank_next;
    logic [3:0]    file_reg, file_next;
    logic [3:0]    castle_reg, castle_next;
    logic [30:0]   num_reg, num_next;
    fsv_numflags_t flags_reg, flags_next;
    logic          out_valid_reg, out_valid_next;
    logic          verdict_reg, verdict_next;

    logic          close_ok;
    logic [4:0]    file_sum;
    logic [34:0]   num_wide;
    logic          num_over;
    logic          fail_byte;

    // take a beat unless it is an end beat and the result slot is blocked
    assign pop = !qstat.empty &&
                 (!head_item.is_end || !out_valid_reg || !out_stall);

    assign out_valid = out_valid_reg;
    assign fen_valid = verdict_reg;

    // token number of the byte, counting a new token
    assign tok_lt6 = 1'b0;
    assign tok_eff = (inside_reg || tok_reg == TOK_MAX) ? tok_reg : tok_reg + 1'b1;

    // shared arithmetic
    assign file_sum = {1'b0, file_reg} + {1'b0, head_item.digit};
    assign num_wide = ({4'b0, num_reg} << 3) + ({4'b0, num_reg} << 1) +
                      {31'b0, head_item.digit};
    assign num_over = num_wide > {4'b0, INT_LIMIT};

    // check at the close of the current token
    always_comb
    begin
        unique case (tok_reg)
            TOK_PLACE:
                close_ok = (rank_reg == '0) && (file_reg == FILE_COUNT);
            TOK_SIDE:
                close_ok = (cic_reg == 2'd1) && first_wb_reg;
            TOK_EP:
                close_ok = ((cic_reg == 2'd1) && first_minus_reg) ||
                           ((cic_reg == 2'd2) && first_ah_reg);
            TOK_HALFMOVE, TOK_FULLMOVE:
            begin
                if (!flags_reg.digit || flags_reg.over)
                begin
                    close_ok = 1'b0;
                end
                else if (flags_reg.nonzero)
                begin
                    close_ok = !flags_reg.minus;
                end
                else
                begin
                    close_ok = (tok_reg == TOK_HALFMOVE);
                end
            end
            default:
                close_ok = 1'b1;
        endcase
    end

    // state update for one beat
    always_comb
    begin
        tok_next         = tok_reg;
        inside_next      = inside_reg;
        failed_next      = failed_reg;
        cic_next         = cic_reg;
        first_minus_next = first_minus_reg;
        first_wb_next    = first_wb_reg;
        first_ah_next    = first_ah_reg;
        rank_next        = rank_reg;
        file_next        = file_reg;
        castle_next      = castle_reg;
        num_next         = num_reg;
        flags_next       = flags_reg;
        verdict_next     = verdict_reg;
        out_valid_next   = out_valid_reg && out_stall;
        fail_byte        = 1'b0;

        if (pop)
        begin
            priority if (head_item.is_end)
            begin
                // verdict, then back to the reset state
                out_valid_next   = 1'b1;
                verdict_next     = !(failed_reg || (inside_reg && !close_ok)) &&
                                   (tok_reg == TOK_FULLMOVE);
                tok_next         = '0;
                inside_next      = 1'b0;
                failed_next      = 1'b0;
                cic_next         = '0;
                first_minus_next = 1'b0;
                first_wb_next    = 1'b0;
                first_ah_next    = 1'b0;
                rank_next        = RANK_TOP;
                file_next        = '0;
                castle_next      = '0;
                num_next         = '0;
                flags_next       = '0;
            end
            else if (head_item.is_space)
            begin
                // whitespace closes an open token
                if (inside_reg)
                begin
                    failed_next      = failed_reg || !close_ok;
                    inside_next      = 1'b0;
                    cic_next         = '0;
                    first_minus_next = 1'b0;
                    first_wb_next    = 1'b0;
                    first_ah_next    = 1'b0;
                    num_next         = '0;
                    flags_next       = '0;
                end
            end
            else
            begin
                inside_next = 1'b1;
                tok_next    = tok_eff;
                unique case (tok_eff)
                    // piece placement
                    TOK_PLACE:
                    begin
                        priority if (head_item.is_slash)
                        begin
                            if (file_reg != FILE_COUNT || rank_reg == '0)
                            begin
                                fail_byte = 1'b1;
                            end
                            else
                            begin
                                rank_next = rank_reg - 1'b1;
                                file_next = '0;
                            end
                        end
                        else if (head_item.is_digit)
                        begin
                            if (head_item.digit == 4'd0 || head_item.digit == 4'd9 ||
                                file_sum > {1'b0, FILE_COUNT})
                            begin
                                fail_byte = 1'b1;
                            end
                            else
                            begin
                                file_next = file_sum[3:0];
                            end
                        end
                        else
                        begin
                            if (!head_item.is_piece || file_reg >= FILE_COUNT)
                            begin
                                fail_byte = 1'b1;
                            end
                            else
                            begin
                                file_next = file_reg + 1'b1;
                            end
                        end
                    end
                    // castling rights
                    TOK_CASTLE:
                    begin
                        priority if (cic_reg != '0 && first_minus_reg)
                        begin
                            fail_byte = 1'b1;
                        end
                        else if (head_item.is_castle)
                        begin
                            fail_byte = castle_reg[head_item.castle_idx];
                            castle_next[head_item.castle_idx] = 1'b1;
                        end
                        else
                        begin
                            fail_byte = !(head_item.is_minus && cic_reg == '0);
                        end
                    end
                    // en passant rank digit
                    TOK_EP:
                    begin
                        fail_byte = (cic_reg == 2'd1) && !head_item.is_18;
                    end
                    // move counters
                    TOK_HALFMOVE, TOK_FULLMOVE:
                    begin
                        priority if (head_item.is_minus && cic_reg == '0)
                        begin
                            flags_next.minus = 1'b1;
                        end
                        else if (head_item.is_digit)
                        begin
                            flags_next.digit = 1'b1;
                            if (head_item.digit != 4'd0)
                            begin
                                flags_next.nonzero = 1'b1;
                            end
                            if (num_over)
                            begin
                                flags_next.over = 1'b1;
                                num_next        = INT_LIMIT;
                            end
                            else
                            begin
                                num_next = num_wide[30:0];
                            end
                        end
                        else
                        begin
                            fail_byte = 1'b1;
                        end
                    end
                    default:
                    begin
                        fail_byte = tok_lt6;
                    end
                endcase
                failed_next = failed_reg || fail_byte;
                // remember what the first byte was
                if (cic_reg == '0)
                begin
                    first_minus_next = head_item.is_minus;
                    first_wb_next    = head_item.is_wb;
                    first_ah_next    = head_item.is_ah;
                end
                if (cic_reg != 2'd3)
                begin
                    cic_next = cic_reg + 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg         <= '0;
            inside_reg      <= 1'b0;
            failed_reg      <= 1'b0;
            cic_reg         <= '0;
            first_minus_reg <= 1'b0;
            first_wb_reg    <= 1'b0;
            first_ah_reg    <= 1'b0;
            rank_reg        <= RANK_TOP;
            file_reg        <= '0;
            castle_reg      <= '0;
            num_reg         <= '0;
            flags_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            tok_reg         <= tok_next;
            inside_reg      <= inside_next;
            failed_reg      <= failed_next;
            cic_reg         <= cic_next;
            first_minus_reg <= first_minus_next;
            first_wb_reg    <= first_wb_next;
            first_ah_reg    <= first_ah_next;
            rank_reg        <= rank_next;
            file_reg        <= file_next;
            castle_reg      <= castle_next;
            num_reg         <= num_next;
            flags_reg       <= flags_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // verdict payload
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

endmodule

FILE: rtl/fen_string_validator.sv
// top level of the position string validator
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   char_code, is_end
//   out      output     out_valid / out_stall fen_valid
//
// one beat per cycle enters while the queue has room; the back part retires one queued beat per cycle
// while the queue is not empty. a verdict is valid in the cycle after its end beat is taken.
// the verdict register holds one result; a stalled result blocks only end beats.
// reset clears the queue and all token state; no clearing pass is needed.
module fen_string_validator
    import fsv_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       is_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       fen_valid
);

    fsv_item_t  push_item;
    fsv_item_t  head_item;
    fsv_qstat_t qstat;
    logic       push;
    logic       pop;

    // classification
    fsv_front u_front
    (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .is_end    (is_end),
        .qstat     (qstat),
        .push      (push),
        .item      (push_item)
    );

    // decoupling queue
    fsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    // checks and verdict
    fsv_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .fen_valid (fen_valid)
    );

`ifndef ASSERT_OFF
    // a retired end beat always leaves a result behind
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_item.is_end) |=> out_valid)
        else $error("end beat retired without a result");

    // the back part never retires from an empty queue
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // a lone push leaves the queue non-empty
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !qstat.empty)
        else $error("pushed beat lost");
`endif

endmodule
